// ===== rtl/core/tlbpt_pkg.sv =====
// Shared widths, constants and controller/datapath interface types for the TLB translator.
package tlbpt_pkg;

    localparam int ADDR_W     = 16;
    localparam int PAGE_W     = 8;
    localparam int OFFSET_W   = 8;
    localparam int FRAME_W    = 8;
    localparam int FCOUNT_W   = 9;
    localparam int PAGE_COUNT = 256;
    localparam int MAX_FRAMES = 256;
    localparam int OUT_W      = 48;

    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 9'd256;
    localparam logic [FCOUNT_W-1:0] FCOUNT_MAX   = 9'd256;

    // Commands issued by the controller, at most one per state.
    typedef struct packed {
        logic accept;
        logic lookup;
        logic check;
        logic victim_rd;
        logic refill;
        logic fault;
        logic load_out;
    } dp_cmd_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic tlb_hit;
        logic resident;
        logic rd_victim;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/tlbpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tlbpt_ctrl.sv =====
// Controller state machine that sequences one translation at a time.
module tlbpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlbpt_pkg::dp_sts_t sts,
    output tlbpt_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_OWNER  = 6'b001000,
        ST_VICTIM = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = sts.tlb_hit ? ST_RESULT : ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = ST_OWNER;
            end
            ST_OWNER:
            begin
                if (sts.resident)
                begin
                    cmd.refill = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (sts.rd_victim)
                begin
                    cmd.fault  = 1'b1;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_VICTIM;
                end
            end
            ST_VICTIM:
            begin
                cmd.victim_rd = 1'b1;
                state_next    = ST_OWNER;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/core/tlbpt_dp.sv =====
// Datapath: TLB, page map and frame owner stores, victim pointer and result register.
module tlbpt_dp #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tlbpt_pkg::FCOUNT_W-1:0]      cfg_wdata,
    input  logic [tlbpt_pkg::ADDR_W-1:0]        in_data,
    input  tlbpt_pkg::dp_cmd_t                  cmd,
    output tlbpt_pkg::dp_sts_t                  sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [tlbpt_pkg::OUT_W-1:0]         out_data
);

    localparam int PTR_W = $clog2(TLB_ENTRIES);
    localparam int PW    = tlbpt_pkg::PAGE_W;
    localparam int FW    = tlbpt_pkg::FRAME_W;
    localparam int CW    = tlbpt_pkg::FCOUNT_W;

    // Item registers
    logic [PW-1:0]                     page_reg;
    logic [tlbpt_pkg::OFFSET_W-1:0]    offset_reg;
    logic [FW-1:0]                     frame_reg;
    logic                              hit_reg;
    logic                              fault_reg;
    logic                              rd_victim_reg;
    logic [FW-1:0]                     ow_addr_reg;

    // Persistent state
    logic [CW-1:0]                     fcount_reg;
    logic [FW-1:0]                     victim_reg;
    logic [FW-1:0]                     victim_next;
    logic [PTR_W-1:0]                  fill_ptr_reg;
    logic [TLB_ENTRIES-1:0]            tlb_valid_reg;
    logic [PW-1:0]                     tlb_page_reg  [TLB_ENTRIES];
    logic [FW-1:0]                     tlb_frame_reg [TLB_ENTRIES];
    logic [tlbpt_pkg::PAGE_COUNT-1:0]  pm_valid_reg;
    logic [tlbpt_pkg::MAX_FRAMES-1:0]  ow_valid_reg;

    // Output register
    logic                              out_valid_reg;
    logic [tlbpt_pkg::OUT_W-1:0]       out_data_reg;

    // Combinational helpers
    logic                              tlb_any;
    logic [FW-1:0]                     tlb_frame;
    logic [CW-1:0]                     active_n;
    logic [FW-1:0]                     victim_f;
    logic [CW-1:0]                     victim_inc;
    logic [FW-1:0]                     pm_rdata;
    logic [PW-1:0]                     ow_rdata;
    logic                              ow_re;
    logic [FW-1:0]                     ow_raddr;
    logic                              old_valid;
    logic                              tlb_write;
    logic [tlbpt_pkg::ADDR_W-1:0]      fetch;

    // Fully associative TLB search; the lowest matching entry wins.
    always_comb
    begin
        tlb_any   = 1'b0;
        tlb_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_reg))
            begin
                tlb_any   = 1'b1;
                tlb_frame = tlb_frame_reg[i];
            end
        end
    end

    // Usable frame count and FIFO victim selection.
    always_comb
    begin
        if (fcount_reg == '0)
        begin
            active_n = CW'(1);
        end
        else if (fcount_reg > tlbpt_pkg::FCOUNT_MAX)
        begin
            active_n = tlbpt_pkg::FCOUNT_MAX;
        end
        else
        begin
            active_n = fcount_reg;
        end
        victim_f    = ({1'b0, victim_reg} >= active_n) ? '0 : victim_reg;
        victim_inc  = {1'b0, victim_f} + CW'(1);
        victim_next = (victim_inc == active_n) ? '0 : victim_inc[FW-1:0];
    end

    assign ow_re     = cmd.check || cmd.victim_rd;
    assign ow_raddr  = (cmd.check && pm_valid_reg[page_reg]) ? pm_rdata : victim_f;
    assign old_valid = ow_valid_reg[ow_addr_reg];
    assign tlb_write = cmd.refill || cmd.fault;

    tlbpt_ram #(
        .WIDTH (FW),
        .DEPTH (tlbpt_pkg::PAGE_COUNT)
    ) u_page_map (
        .clk   (clk),
        .we    (cmd.fault),
        .waddr (page_reg),
        .wdata (ow_addr_reg),
        .re    (cmd.lookup),
        .raddr (page_reg),
        .rdata (pm_rdata)
    );

    tlbpt_ram #(
        .WIDTH (PW),
        .DEPTH (tlbpt_pkg::MAX_FRAMES)
    ) u_frame_owner (
        .clk   (clk),
        .we    (cmd.fault),
        .waddr (ow_addr_reg),
        .wdata (page_reg),
        .re    (ow_re),
        .raddr (ow_raddr),
        .rdata (ow_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg    <= tlbpt_pkg::FCOUNT_RESET;
            victim_reg    <= '0;
            fill_ptr_reg  <= '0;
            tlb_valid_reg <= '0;
            pm_valid_reg  <= '0;
            ow_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fcount_reg <= cfg_wdata;
            end
            if (cmd.fault)
            begin
                // Unmap the evicted page and drop its TLB entries first.
                if (old_valid)
                begin
                    pm_valid_reg[ow_rdata] <= 1'b0;
                    for (int i = 0; i < TLB_ENTRIES; i++)
                    begin
                        if (tlb_valid_reg[i] && (tlb_page_reg[i] == ow_rdata))
                        begin
                            tlb_valid_reg[i] <= 1'b0;
                        end
                    end
                end
                pm_valid_reg[page_reg]    <= 1'b1;
                ow_valid_reg[ow_addr_reg] <= 1'b1;
                victim_reg                <= victim_next;
            end
            if (tlb_write)
            begin
                tlb_valid_reg[fill_ptr_reg] <= 1'b1;
                fill_ptr_reg <= (fill_ptr_reg == PTR_W'(TLB_ENTRIES - 1)) ?
                                '0 : fill_ptr_reg + PTR_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg   <= in_data[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
            offset_reg <= in_data[tlbpt_pkg::OFFSET_W-1:0];
            hit_reg    <= 1'b0;
            fault_reg  <= 1'b0;
        end
        if (cmd.lookup)
        begin
            hit_reg   <= tlb_any;
            frame_reg <= tlb_frame;
        end
        if (cmd.check)
        begin
            rd_victim_reg <= !pm_valid_reg[page_reg];
            ow_addr_reg   <= ow_raddr;
        end
        if (cmd.victim_rd)
        begin
            rd_victim_reg <= 1'b1;
            ow_addr_reg   <= ow_raddr;
        end
        if (cmd.refill)
        begin
            frame_reg <= ow_addr_reg;
        end
        if (cmd.fault)
        begin
            frame_reg <= ow_addr_reg;
            fault_reg <= 1'b1;
        end
        if (tlb_write)
        begin
            tlb_page_reg[fill_ptr_reg]  <= page_reg;
            tlb_frame_reg[fill_ptr_reg] <= ow_addr_reg;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {6'b0, fetch, fault_reg, hit_reg, frame_reg, frame_reg, offset_reg};
        end
    end

    assign fetch = fault_reg ? {page_reg, {tlbpt_pkg::OFFSET_W{1'b0}}} : '0;

    assign sts.tlb_hit   = tlb_any;
    assign sts.resident  = !rd_victim_reg && old_valid && (ow_rdata == page_reg);
    assign sts.rd_victim = rd_victim_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/tlb_page_table_translator_top.sv =====
// Top level of the TLB and demand-paged page table translator.
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+-----------------------------------------
//  s_*     | in        | s_tvalid/s_tready  | logical address
//  m_*     | out       | m_tvalid/m_tready  | physical address, frame, hit, fault, fetch
//  cfg_*   | in        | cfg_we             | frame count register
//
// One translation is in flight at a time. A transfer that hits in the TLB passes through
// lookup and result; a TLB miss with the page resident adds the page map and frame owner
// checks, and a page fault adds them too, plus a victim re-read for a stale mapping.
// The page map and frame owner RAMs each have one read port, so reads are sequential.
// Reset clears all valid bits at once, so no clearing pass is needed after rst_n rises.
// The result register lets a new address be accepted while the previous result is
// stalled on m_tready; the controller waits only when it needs that register again.
module tlb_page_table_translator_top #(
    parameter int TLB_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // Frame count register (1..256; zero acts as 1, larger values as 256).
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] logical_address
    input  logic [15:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] physical_address, [23:16] frame_number, [24] tlb_hit,
    // [25] page_fault, [41:26] fetch_offset, [47:42] zero
    output logic [47:0] m_tdata
);

    tlbpt_pkg::dp_cmd_t cmd;
    tlbpt_pkg::dp_sts_t sts;

    // The controller walks each address through TLB lookup and, on a miss, page map check,
    // frame owner check and, on a fault, frame allocation.
    tlbpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds every store and the result register.
    tlbpt_dp #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    // A translation comes either from the TLB or from a fault, never both.
    a_hit_xor_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[24] && m_tdata[25]))
        else $error("result flags both TLB hit and page fault");

    // The fetch offset is only reported on a fault.
    a_fetch_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[25]) |-> (m_tdata[41:26] == 16'd0))
        else $error("fetch offset reported without a page fault");

    // The frame field and the upper half of the physical address agree.
    a_frame_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:8] == m_tdata[23:16]))
        else $error("physical address does not match frame number");

    // Only one address is in flight: ready drops right after each input transfer.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second address accepted while one is in flight");
`endif

endmodule
